// ----- rtl/core/lfu_pkg.sv -----
// Shared types and constants for the LFU cache table.
package lfu_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic        [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture item, clear scan state
    logic rd;      // read entry at scan address, advance address
    logic commit;  // write back and load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cap_zero;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/lfu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lfu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/lfu_ctrl.sv -----
// Sequencer for the LFU cache: accept, scan, write back, hand off result.
module lfu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lfu_pkg::status_t status_i,
  output lfu_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= status_i.cap_zero ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last entry's data compares here
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.rd     = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_FINISH) && status_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/core/lfu_dp.sv -----
// LFU cache datapath: entry RAM, valid bits, scan compare, write back, result register.
module lfu_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lfu_pkg::in_t                       in_data_i,
  input  logic                               cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]          cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output lfu_pkg::out_t                      out_data_o,
  input  lfu_pkg::cmd_t                      cmd_i,
  output lfu_pkg::status_t                   status_o
);

  localparam int unsigned IW = lfu_pkg::IDX_W;
  localparam int unsigned OW = lfu_pkg::OCC_W;
  localparam int unsigned DW = lfu_pkg::DATA_W;

  // configuration and global state
  logic [lfu_pkg::CAP_W-1:0] cap_q;
  logic [OW-1:0]             cap_eff;
  logic [OW-1:0]             occ_q;
  logic [DW-1:0]             clock_q;
  logic [lfu_pkg::ENTRIES-1:0] valid_q;

  // captured item
  logic          op_q;
  logic [DW-1:0] key_q;
  logic [DW-1:0] val_q;

  // scan state
  logic [IW-1:0] addr_q;
  logic [IW-1:0] cmp_idx_q;
  logic          rd_vld_q;
  logic          found_q;
  logic [IW-1:0] match_idx_q;
  lfu_pkg::entry_t match_q;
  logic          have_vic_q;
  logic [IW-1:0] vic_idx_q;
  logic [DW-1:0] vic_cnt_q;
  logic [DW-1:0] vic_stamp_q;
  logic          have_free_q;
  logic [IW-1:0] free_idx_q;

  // output register
  logic          out_valid_q;
  lfu_pkg::out_t out_q;

  lfu_pkg::entry_t rd_entry;
  lfu_pkg::entry_t wr_entry;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic            ins_en;
  logic            occ_inc;
  logic            hit;
  logic            cur_valid;
  logic            better;
  logic [DW-1:0]   clock_nxt;
  logic [DW-1:0]   sat_cnt;

  lfu_ram #(
    .WIDTH (lfu_pkg::ENTRY_W),
    .DEPTH (lfu_pkg::ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_entry),
    .raddr_i (addr_q),
    .rdata_o (rd_entry)
  );

  assign cap_eff = (32'(cap_q) > lfu_pkg::ENTRIES) ? OW'(lfu_pkg::ENTRIES) : OW'(cap_q);

  // scan compare on the entry read last cycle
  assign cur_valid = valid_q[cmp_idx_q];
  assign better    = !have_vic_q || (rd_entry.count < vic_cnt_q) ||
                     ((rd_entry.count == vic_cnt_q) && (rd_entry.stamp < vic_stamp_q));

  // write-back decision
  assign clock_nxt = clock_q + 1'b1;
  assign sat_cnt   = (match_q.count == '1) ? match_q.count : match_q.count + 1'b1;
  assign hit       = (cap_eff != '0) && found_q;

  always_comb begin
    wr_en    = 1'b0;
    ins_en   = 1'b0;
    occ_inc  = 1'b0;
    wr_idx   = match_idx_q;
    wr_entry = match_q;
    if (cmd_i.commit && (cap_eff != '0)) begin
      if (found_q) begin
        wr_en          = 1'b1;
        wr_entry.key   = key_q;
        wr_entry.value = (op_q == lfu_pkg::OP_PUT) ? val_q : match_q.value;
        wr_entry.count = sat_cnt;
        wr_entry.stamp = clock_nxt;
      end else if (op_q == lfu_pkg::OP_PUT) begin
        wr_entry.key   = key_q;
        wr_entry.value = val_q;
        wr_entry.count = DW'(1);
        wr_entry.stamp = clock_nxt;
        if ((occ_q < cap_eff) && have_free_q) begin
          wr_en   = 1'b1;
          ins_en  = 1'b1;
          occ_inc = 1'b1;
          wr_idx  = free_idx_q;
        end else if (have_vic_q) begin
          wr_en  = 1'b1;
          ins_en = 1'b1;
          wr_idx = vic_idx_q;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lfu_pkg::CAP_W'(16);
      occ_q       <= '0;
      clock_q     <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      addr_q      <= '0;
      found_q     <= 1'b0;
      have_vic_q  <= 1'b0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        addr_q      <= '0;
        found_q     <= 1'b0;
        have_vic_q  <= 1'b0;
        have_free_q <= 1'b0;
      end else if (cmd_i.rd) begin
        addr_q <= addr_q + 1'b1;
      end
      if (rd_vld_q) begin
        if (cur_valid) begin
          if (!found_q && (rd_entry.key == key_q)) begin
            found_q <= 1'b1;
          end
          if (better) begin
            have_vic_q <= 1'b1;
          end
        end else if (!have_free_q) begin
          have_free_q <= 1'b1;
        end
      end
      if (wr_en) begin
        clock_q <= clock_nxt;
      end
      if (ins_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (occ_inc) begin
        occ_q <= occ_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.lookup_key;
      val_q <= in_data_i.write_value;
    end
    if (cmd_i.rd) begin
      cmp_idx_q <= addr_q;
    end
    if (rd_vld_q) begin
      if (cur_valid) begin
        if (!found_q && (rd_entry.key == key_q)) begin
          match_idx_q <= cmp_idx_q;
          match_q     <= rd_entry;
        end
        if (better) begin
          vic_idx_q   <= cmp_idx_q;
          vic_cnt_q   <= rd_entry.count;
          vic_stamp_q <= rd_entry.stamp;
        end
      end else if (!have_free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (cmd_i.commit) begin
      out_q.hit        <= hit;
      out_q.read_value <= (hit && (op_q == lfu_pkg::OP_GET)) ? match_q.value : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o           = '0;
    status_o.cap_zero  = (cap_eff == '0);
    status_o.scan_last = (addr_q == IW'(lfu_pkg::ENTRIES - 1));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// ----- rtl/core/lfu_cache_table_unit.sv -----
// LFU cache table top level: controller plus datapath.
// An item with capacity on is accepted, then scanned with one RAM read per entry, then passes a
// drain state and a write-back state before its result is registered.
// A new item is accepted only in idle, after the previous write-back; with capacity zero an
// item skips the scan. A waiting result does not block the next accept.
// Reset clears valid bits, occupancy and use clock at once; capacity resets to 16.
module lfu_cache_table_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lfu_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lfu_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_data_i
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- tb/tb_lfu_cache_table_unit.sv -----
// Self-checking testbench for the LFU cache table: predicts and checks get/put results.
module tb_lfu_cache_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned PHASES = 10;
  localparam int unsigned POOL_MAX = 32;

  // Tracks cache contents and holds the results still owed by the block.
  class lfu_scoreboard;
    logic              held[ENTRIES];
    logic [DATA_W-1:0] tag[ENTRIES];
    logic [DATA_W-1:0] data[ENTRIES];
    logic [DATA_W-1:0] uses[ENTRIES];
    logic [DATA_W-1:0] stamp[ENTRIES];
    logic [DATA_W-1:0] use_clock;
    int unsigned       occupancy;
    logic [CAP_W-1:0]  capacity;
    out_t              owed_results[$];
    int unsigned       fails;

    function new();
      foreach (held[i]) begin
        held[i]  = 1'b0;
        tag[i]   = '0;
        data[i]  = '0;
        uses[i]  = '0;
        stamp[i] = '0;
      end
      use_clock = '0;
      occupancy = 0;
      capacity  = CAP_W'(16);
      fails     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function out_t lookup_or_insert(in_t item);
      out_t        res;
      int unsigned eff;
      int          match;
      int          victim;
      int          free_slot;
      int          slot;
      bit          found;
      bit          have_victim;
      bit          have_free;
      res = '0;
      eff = (capacity > ENTRIES) ? ENTRIES : capacity;
      match = 0;
      victim = 0;
      free_slot = 0;
      found = 1'b0;
      have_victim = 1'b0;
      have_free = 1'b0;
      if (eff == 0) return res;
      for (int i = 0; i < ENTRIES; i++) begin
        if (held[i]) begin
          if (!found && tag[i] == item.lookup_key) begin
            found = 1'b1;
            match = i;
          end
          if (!have_victim || uses[i] < uses[victim] ||
              (uses[i] == uses[victim] && stamp[i] < stamp[victim])) begin
            have_victim = 1'b1;
            victim = i;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      if (found) begin
        res.hit = 1'b1;
        if (uses[match] != '1) uses[match] = uses[match] + 1;
        use_clock = use_clock + 1;
        stamp[match] = use_clock;
        if (item.operation == OP_GET) res.read_value = data[match];
        else data[match] = item.write_value;
        return res;
      end
      if (item.operation == OP_GET) return res;
      if (occupancy < eff && have_free) begin
        slot = free_slot;
        occupancy++;
      end else if (have_victim) begin
        slot = victim;
      end else begin
        return res;
      end
      held[slot]  = 1'b1;
      tag[slot]   = item.lookup_key;
      data[slot]  = item.write_value;
      uses[slot]  = 1;
      use_clock   = use_clock + 1;
      stamp[slot] = use_clock;
      return res;
    endfunction

    function void note_item(in_t item);
      owed_results.push_back(lookup_or_insert(item));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: hit %0d read_value %0d", got.hit, got.read_value);
        fails++;
        return;
      end
      want = owed_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        fails++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
        fails++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lfu_scoreboard    sb = new();
  int unsigned      cycle_count = 0;
  logic [DATA_W-1:0] key_pool[POOL_MAX];
  int unsigned      pool_size = 1;

  lfu_cache_table_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Results first: anything leaving this edge belongs to an older item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
    end
  end

  // Receiver stall pattern: the mode is re-drawn at random, paced by the cycle counter.
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 4);
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        3:       out_stall <= cycle_count[2];
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  function automatic in_t build_item(logic op, logic [DATA_W-1:0] key,
                                     logic signed [DATA_W-1:0] val);
    in_t item;
    item.operation   = op;
    item.lookup_key  = key;
    item.write_value = val;
    return item;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_item();
    logic [DATA_W-1:0] key;
    logic              op;
    op  = $urandom_range(0, 1) ? OP_PUT : OP_GET;
    key = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom) :
          key_pool[$urandom_range(0, pool_size - 1)];
    return build_item(op, key, pick_value());
  endfunction

  // Pool a little larger than the capacity so gets hit and puts evict.
  task automatic refill_pool(logic [CAP_W-1:0] cap);
    int unsigned eff;
    eff = (cap > ENTRIES) ? ENTRIES : cap;
    pool_size = eff + $urandom_range(1, 6);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int i = 0; i < POOL_MAX; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = '0;
        1:       key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  task automatic drive_item(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (ENTRIES + 6) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(cap);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        drive_item(random_item());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
  endtask

  logic [CAP_W-1:0] phase_caps[PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3,
                                           5'd8, 5'd2, 5'd17, 5'd5, 5'd16};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty cache, extreme keys and values, update of a present key.
    drive_item(build_item(OP_GET, 32'h0, 32'sd0));
    drive_item(build_item(OP_PUT, 32'h0, 32'sh7FFFFFFF));
    drive_item(build_item(OP_GET, 32'h0, 32'sd9));
    drive_item(build_item(OP_PUT, 32'hFFFFFFFF, 32'sh80000000));
    drive_item(build_item(OP_PUT, 32'hFFFFFFFF, -32'sd1));
    drive_item(build_item(OP_GET, 32'hFFFFFFFF, 32'sh7FFFFFFF));
    drive_item(build_item(OP_GET, 32'h00012345, 32'sd0));
    in_valid <= 1'b0;
    wait_idle();

    // Disabled: held entries must not hit, puts are dropped.
    write_capacity(5'd0);
    drive_item(build_item(OP_GET, 32'h0, 32'sd0));
    drive_item(build_item(OP_PUT, 32'h00000005, 32'sd5));
    drive_item(build_item(OP_GET, 32'hFFFFFFFF, 32'sd0));
    in_valid <= 1'b0;
    wait_idle();

    // Full at two: equal counts, so eviction falls to the older stamp.
    write_capacity(5'd2);
    drive_item(build_item(OP_GET, 32'h0, 32'sd0));
    drive_item(build_item(OP_PUT, 32'h55555555, 32'sd77));
    drive_item(build_item(OP_GET, 32'h0, 32'sd0));
    in_valid <= 1'b0;
    wait_idle();

    // Capacity below occupancy: one victim per new key.
    write_capacity(5'd1);
    drive_item(build_item(OP_PUT, 32'hAAAAAAAA, -32'sd2));
    drive_item(build_item(OP_GET, 32'h55555555, 32'sd0));
    drive_item(build_item(OP_GET, 32'hAAAAAAAA, 32'sd0));
    in_valid <= 1'b0;
    wait_idle();

    // Capacity beyond the table acts as a full table.
    write_capacity(5'd31);
    for (int i = 0; i < 8; i++)
      drive_item(build_item(OP_PUT, 32'h0F0F0F0F * (i + 1), pick_value()));
    in_valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      refill_pool(phase_caps[p]);
      run_random(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
